// ===== rtl/core/round_robin_task_queue_macros.svh =====
// Assertion macros shared by the round-robin task queue checker.
`ifndef ROUND_ROBIN_TASK_QUEUE_MACROS_SVH
`define ROUND_ROBIN_TASK_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RRTQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("round_robin_task_queue: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RRTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("round_robin_task_queue: next-cycle check failed");

`endif

// ===== rtl/core/rrtq_pkg.sv =====
// Package of the round-robin task queue: sizes, codes, entry and cell control types.
`default_nettype none

package rrtq_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 4;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 3;
  localparam int QUANT_W = 16;
  localparam int TCNT_W  = 5;

  localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(10);
  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(10);

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ADD   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEL   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_EXEC  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIND  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

  // Result word layout, lowest bit first.
  localparam int OUT_W       = 48;
  localparam int OUT_FOUND   = 3;
  localparam int OUT_RAN_ID  = 4;
  localparam int OUT_RAN_LFT = 20;
  localparam int OUT_FIN     = 36;
  localparam int OUT_TCNT    = 37;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] rem;
    logic [PRIO_W-1:0]    prio;
  } entry_t;

  typedef struct packed {
    logic capture;   // latch the id compare of every cell
    logic load_new;  // first empty cell takes the new entry
    logic shift;     // cells at or after the first hit take their right neighbour
    logic rotate;    // last occupied cell takes the rotated head entry
    logic clear;     // drop every entry
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrtq_cell.sv =====
// One slot of the task chain: holds an entry, its valid bit and its id-match flag.
`default_nettype none

module rrtq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rrtq_pkg::cell_ctl_t ctl,
  input  wire logic [15:0]        key,
  input  wire rrtq_pkg::entry_t   load_entry,
  input  wire logic               prev_valid,
  input  wire logic               next_valid,
  input  wire rrtq_pkg::entry_t   next_entry,
  input  wire logic               hit_in,
  output logic                    hit_out,
  output logic                    valid,
  output rrtq_pkg::entry_t        entry
);
  import rrtq_pkg::*;

  logic   valid_r, valid_nxt;
  logic   match_r, match_nxt;
  entry_t entry_r, entry_nxt;
  logic   do_shift, do_add, do_rot;

  assign hit_out  = hit_in | match_r;
  assign do_shift = ctl.shift & hit_out;
  assign do_add   = ctl.load_new & ~valid_r & prev_valid;
  assign do_rot   = ctl.rotate & valid_r & ~next_valid;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    match_nxt = match_r;
    if (ctl.capture) begin
      match_nxt = valid_r && (entry_r.id == key);
    end
    priority if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (do_add || do_rot) begin
      valid_nxt = 1'b1;
      entry_nxt = load_entry;
    end else if (do_shift) begin
      valid_nxt = next_valid;
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== rtl/core/round_robin_task_queue.sv =====
// Top level of the round-robin task queue: control, count and a chain of task cells.
//
//  Channel   Direction  Handshake              Payload
//  in_       slave      in_tvalid / in_tready  in_tuser: func; in_tdata: id, burst, priority
//  out_      master     out_tvalid/out_tready  out_tdata: status .. task_count
//  cfg_      write      cfg_we                 cfg_wdata: quantum
//
// Each item passes through S_IDLE and S_EXEC: the accept edge latches the operands and
// every cell compares its id with the key, and the commit edge in S_EXEC applies the
// chain update and loads the result register. A stalled result holds the item in
// S_EXEC, but the next item is still accepted while a result waits. Reset
// (synchronous, active low) clears the valid bits of all cells together; no clearing
// pass is needed.
`default_nettype none

module round_robin_task_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // slave side
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // [2:0] func
  input  wire logic [39:0] in_tdata,   // [15:0] task_id, [31:16] burst_time,
                                       // [35:32] task_priority, [39:36] zero
  // master side
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [2:0] status, [3] found, [19:4] ran_id,
                                       // [35:20] ran_left, [36] finished,
                                       // [41:37] task_count, [47:42] zero
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata   // quantum
);
  import rrtq_pkg::*;

  // Control states: waiting for an item, or committing the latched one.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                state_r, state_nxt;
  logic [QUANT_W-1:0]  quantum_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [ID_W-1:0]     id_r;
  logic [BURST_W-1:0]  burst_r;
  logic [PRIO_W-1:0]   prio_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic                accept, out_free, commit;
  cell_ctl_t           ctl;
  entry_t              load_entry;

  // Chain wiring: entry i of the arrays belongs to cell i, the extra entry is the
  // empty position past the last cell.
  logic                valid_c [MAX_TASKS+1];
  entry_t              entry_c [MAX_TASKS+1];
  logic                hit_c   [MAX_TASKS+1];

  // Result fields.
  logic [STAT_W-1:0]   status;
  logic                found, finished;
  logic [ID_W-1:0]     ran_id;
  logic [TIME_BITS-1:0] ran_left;
  logic                any_hit, empty, add_bad;
  logic [31:0]         head_rem32, quant32;
  logic [TIME_BITS-1:0] head_left;

  assign accept    = in_tvalid & in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = ~out_valid_r | out_tready;
  assign commit    = (state_r == S_EXEC) & out_free;

  // The last cell sees nothing to its right.
  assign valid_c[MAX_TASKS] = 1'b0;
  assign entry_c[MAX_TASKS] = '0;

  // An execute seeds the hit chain at the head so every occupied cell shifts;
  // every other operation starts it clear.
  assign hit_c[0] = (func_r == FN_EXEC);

  genvar g;
  generate
    for (g = 0; g < MAX_TASKS; g++) begin : g_cell
      rrtq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key        (accept ? in_tdata[15:0] : id_r),
        .load_entry (load_entry),
        .prev_valid ((g == 0) ? 1'b1 : valid_c[(g == 0) ? 0 : g-1]),
        .next_valid (valid_c[g+1]),
        .next_entry (entry_c[g+1]),
        .hit_in     (hit_c[g]),
        .hit_out    (hit_c[g+1]),
        .valid      (valid_c[g]),
        .entry      (entry_c[g])
      );
    end
  endgenerate

  // For add, delete and find the seed is clear, so the chain end is the OR of matches.
  assign any_hit = hit_c[MAX_TASKS];
  assign empty   = (count_r == '0);

  // A burst of zero, a burst that does not fit the time field or a priority
  // outside one to ten makes an add invalid.
  assign add_bad = (burst_r == '0) || ((32'(burst_r) >> TIME_BITS) != 32'd0) ||
                   (prio_r < PRIO_MIN) || (prio_r > PRIO_MAX);

  assign head_rem32 = 32'(entry_c[0].rem);
  assign quant32    = 32'(quantum_r);
  assign head_left  = TIME_BITS'(head_rem32 - quant32);

  always_comb begin
    status     = ST_OK;
    found      = 1'b0;
    finished   = 1'b0;
    ran_id     = '0;
    ran_left   = '0;
    count_nxt  = count_r;
    ctl        = '0;
    load_entry = '{id: id_r, rem: TIME_BITS'(burst_r), prio: prio_r};
    ctl.capture = accept;
    if (state_r == S_EXEC) begin
      unique case (func_r)
        FN_ADD: begin
          priority if (add_bad) begin
            status = ST_INVALID;
          end else if (any_hit) begin
            status = ST_DUP;
          end else if (count_r == CNT_W'(MAX_TASKS)) begin
            status = ST_FULL;
          end else begin
            ctl.load_new = commit;
            count_nxt    = count_r + CNT_W'(1);
          end
        end
        FN_DEL: begin
          priority if (empty) begin
            status = ST_EMPTY;
          end else if (!any_hit) begin
            status = ST_NOTFOUND;
          end else begin
            ctl.shift = commit;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        FN_EXEC: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ran_id    = entry_c[0].id;
            ctl.shift = commit;
            if (quant32 >= head_rem32) begin
              // The head task completes and leaves the ring.
              finished  = 1'b1;
              count_nxt = count_r - CNT_W'(1);
            end else begin
              // The head moves to the tail with its reduced time.
              ran_left   = head_left;
              ctl.rotate = commit;
              load_entry = '{id: entry_c[0].id, rem: head_left, prio: entry_c[0].prio};
            end
          end
        end
        FN_FIND: begin
          found = any_hit;
        end
        FN_CLEAR: begin
          if (empty) begin
            status = ST_EMPTY;
          end
          ctl.clear = commit;
          count_nxt = '0;
        end
        default: begin
          status = ST_INVALID;
        end
      endcase
    end
  end

  // Next state and result register.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[STAT_W-1:0]                  = status;
          out_data_nxt[OUT_FOUND]                   = found;
          out_data_nxt[OUT_RAN_ID +: ID_W]          = ran_id;
          out_data_nxt[OUT_RAN_LFT +: BURST_W]      = BURST_W'(ran_left);
          out_data_nxt[OUT_FIN]                     = finished;
          out_data_nxt[OUT_TCNT +: TCNT_W]          = TCNT_W'(count_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      quantum_r   <= QUANT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      func_r  <= in_tuser;
      id_r    <= in_tdata[15:0];
      burst_r <= in_tdata[31:16];
      prio_r  <= in_tdata[35:32];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/rrtq_checker.sv =====
// Port-level checker for the round-robin task queue, bound to the top level.
`default_nettype none

`include "round_robin_task_queue_macros.svh"

module rrtq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);
  import rrtq_pkg::*;

  logic [STAT_W-1:0] st;
  logic [TCNT_W-1:0] tcnt;

  assign st   = out_tdata[STAT_W-1:0];
  assign tcnt = out_tdata[OUT_TCNT +: TCNT_W];

  // A result that is not taken stays on the port unchanged.
  `RRTQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The count never goes past the capacity of the chain.
  `RRTQ_ASSERT_NOW(a_cnt_range, out_tvalid, 32'(tcnt) <= MAX_TASKS)

  // A finished task reports success with no time left.
  `RRTQ_ASSERT_NOW(a_fin_ok, out_tvalid && out_tdata[OUT_FIN],
                   st == ST_OK && out_tdata[OUT_RAN_LFT +: 16] == 16'd0)

  // An accepted item blocks the input in the cycle that follows, while it waits to commit.
  `RRTQ_ASSERT_NEXT(a_two_cycle, in_tvalid && in_tready, !in_tready)

endmodule

bind round_robin_task_queue rrtq_checker u_rrtq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
